[sv/lrmc_pkg.sv]
// ----------------------------------------------------------------------------
// LED rainbow mode controller package
// Shared types, command codes and the hue ramp coefficient table.
// ----------------------------------------------------------------------------
package lrmc_pkg;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_OFF    = 3'd1,
        ACT_ON     = 3'd2,
        ACT_TOGGLE = 3'd3,
        ACT_RED    = 3'd4,
        ACT_GREEN  = 3'd5,
        ACT_BLUE   = 3'd6,
        ACT_CUSTOM = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_RAINBOW = 2'd1,
        MODE_SOLID   = 2'd2
    } t_mode;

    localparam int unsigned SectorLen    = 60;
    localparam int unsigned NumSectors   = 6;
    localparam int unsigned RampFracBits = 16;

    localparam int unsigned SectorW = $clog2(NumSectors);
    localparam int unsigned FracW   = $clog2(SectorLen);
    localparam int unsigned CoefW   = RampFracBits + 1;

    typedef logic [SectorW-1:0] t_sector;
    typedef logic [FracW-1:0]   t_frac;
    typedef logic [CoefW-1:0]   t_ramp_coef;
    typedef t_ramp_coef t_ramp_tab [0:SectorLen];

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] custom_red;
        logic [7:0] custom_green;
        logic [7:0] custom_blue;
        logic       want_rainbow;
    } t_cmd;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Coefficient k(f) = ceil(f * 2^16 / 60). For any 8-bit level B,
    // (B * k(f)) >> 16 equals floor(f * B / 60) exactly.
    function automatic t_ramp_tab build_ramp_tab();
        t_ramp_tab tab;
        for (int i = 0; i <= SectorLen; i++) begin
            tab[i] = CoefW'((i * (1 << RampFracBits) + SectorLen - 1) / SectorLen);
        end
        return tab;
    endfunction

    localparam t_ramp_tab RampTab = build_ramp_tab();

endpackage

[sv/lrmc_cmd_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command or tick item.
// ----------------------------------------------------------------------------
interface lrmc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] custom_red;
    logic [7:0] custom_green;
    logic [7:0] custom_blue;
    logic       want_rainbow;

    modport source (
        output valid, action, custom_red, custom_green, custom_blue, want_rainbow,
        input  ready
    );
    modport sink (
        input  valid, action, custom_red, custom_green, custom_blue, want_rainbow,
        output ready
    );
endinterface

[sv/lrmc_color_if.sv]
// ----------------------------------------------------------------------------
// Color channel
// Valid/ready channel that carries one strip color.
// ----------------------------------------------------------------------------
interface lrmc_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (
        output valid, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue,
        output ready
    );
endinterface

[sv/lrmc_in_reg.sv]
// ----------------------------------------------------------------------------
// Command input register
// Captures one command transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module lrmc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lrmc_cmd_if.sink          i_cmd,
    input  logic              i_advance,
    output logic              o_valid,
    output lrmc_pkg::t_cmd    o_cmd
);

    logic           r_valid;
    lrmc_pkg::t_cmd r_cmd;
    logic           load;

    assign i_cmd.ready = !r_valid || i_advance;
    assign load        = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd.action       <= i_cmd.action;
            r_cmd.custom_red   <= i_cmd.custom_red;
            r_cmd.custom_green <= i_cmd.custom_green;
            r_cmd.custom_blue  <= i_cmd.custom_blue;
            r_cmd.want_rainbow <= i_cmd.want_rainbow;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

[sv/lrmc_hue_wheel.sv]
// ----------------------------------------------------------------------------
// Hue wheel
// Maps a hue (sector and offset) and a peak level to an RGB color.
// ----------------------------------------------------------------------------
module lrmc_hue_wheel (
    input  lrmc_pkg::t_sector i_sector,
    input  lrmc_pkg::t_frac   i_frac,
    input  logic [7:0]        i_bright,
    output lrmc_pkg::t_rgb    o_rgb
);

    localparam int unsigned ProdW = 8 + lrmc_pkg::CoefW;

    lrmc_pkg::t_frac  fall_idx;
    logic [ProdW-1:0] rise_prod;
    logic [ProdW-1:0] fall_prod;
    logic [7:0]       rise;
    logic [7:0]       fall;

    assign fall_idx  = lrmc_pkg::FracW'(lrmc_pkg::SectorLen - {26'd0, i_frac});
    assign rise_prod = ProdW'(i_bright) * ProdW'(lrmc_pkg::RampTab[i_frac]);
    assign fall_prod = ProdW'(i_bright) * ProdW'(lrmc_pkg::RampTab[fall_idx]);
    assign rise      = rise_prod[lrmc_pkg::RampFracBits +: 8];
    assign fall      = fall_prod[lrmc_pkg::RampFracBits +: 8];

    always_comb begin
        case (i_sector)
            3'd0:    o_rgb = '{red: i_bright, green: rise,     blue: 8'd0};
            3'd1:    o_rgb = '{red: fall,     green: i_bright, blue: 8'd0};
            3'd2:    o_rgb = '{red: 8'd0,     green: i_bright, blue: rise};
            3'd3:    o_rgb = '{red: 8'd0,     green: fall,     blue: i_bright};
            3'd4:    o_rgb = '{red: rise,     green: 8'd0,     blue: i_bright};
            default: o_rgb = '{red: i_bright, green: 8'd0,     blue: fall};
        endcase
    end

endmodule

[sv/led_rainbow_mode_controller_unit.sv]
// ----------------------------------------------------------------------------
// LED rainbow mode controller
// Off / rainbow / solid mode controller that emits one strip color per
// emitting command or tick.
// ----------------------------------------------------------------------------
// The block takes one command or tick per cycle while the color channel does
// not stall. A command is held in an input register. The mode logic and hue
// wheel then decide the result and load it into the output register, which
// drives the color channel. A full item follows every clock while no stall
// holds it. The output register parts the two channels, so silent commands
// (on, toggle to rainbow, custom rainbow) pass through while a color waits to
// be taken. Brightness resets to full scale. The user must set brightness
// through the write port only while no item is in flight (not enforced).
module led_rainbow_mode_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrmc_cmd_if.sink    i_cmd,
    lrmc_color_if.source o_color,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    logic               cmd_valid;
    lrmc_pkg::t_cmd     cmd;
    lrmc_pkg::t_action  act;
    logic               emits;
    logic               advance;
    lrmc_pkg::t_rgb     wheel_rgb;
    lrmc_pkg::t_rgb     result;

    logic [7:0]         r_bright;
    lrmc_pkg::t_mode    r_mode,   n_mode;
    lrmc_pkg::t_sector  r_sector, n_sector;
    lrmc_pkg::t_frac    r_frac,   n_frac;
    lrmc_pkg::t_rgb     r_solid,  n_solid;
    logic               r_out_valid, n_out_valid;
    lrmc_pkg::t_rgb     r_out;

    lrmc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_advance (advance),
        .o_valid   (cmd_valid),
        .o_cmd     (cmd)
    );

    lrmc_hue_wheel u_hue_wheel (
        .i_sector (r_sector),
        .i_frac   (r_frac),
        .i_bright (r_bright),
        .o_rgb    (wheel_rgb)
    );

    assign act = lrmc_pkg::t_action'(cmd.action);

    always_comb begin
        case (act)
            lrmc_pkg::ACT_ON:     emits = 1'b0;
            lrmc_pkg::ACT_TOGGLE: emits = (r_mode != lrmc_pkg::MODE_OFF);
            lrmc_pkg::ACT_CUSTOM: emits = !cmd.want_rainbow;
            default:              emits = 1'b1;
        endcase
    end

    // A silent item can retire even while the output register is stalled.
    assign advance = cmd_valid && (!r_out_valid || o_color.ready || !emits);

    always_comb begin
        n_mode   = r_mode;
        n_sector = r_sector;
        n_frac   = r_frac;
        n_solid  = r_solid;
        result   = '0;
        case (act)
            lrmc_pkg::ACT_TICK: begin
                case (r_mode)
                    lrmc_pkg::MODE_RAINBOW: begin
                        result = wheel_rgb;
                        if (r_frac == lrmc_pkg::FracW'(lrmc_pkg::SectorLen - 1)) begin
                            n_frac = '0;
                            if (r_sector == lrmc_pkg::SectorW'(lrmc_pkg::NumSectors - 1)) begin
                                n_sector = '0;
                            end else begin
                                n_sector = r_sector + 1'b1;
                            end
                        end else begin
                            n_frac = r_frac + 1'b1;
                        end
                    end
                    lrmc_pkg::MODE_SOLID: result = r_solid;
                    default:              result = '0;
                endcase
            end
            lrmc_pkg::ACT_OFF: begin
                n_mode = lrmc_pkg::MODE_OFF;
            end
            lrmc_pkg::ACT_ON: begin
                n_mode = lrmc_pkg::MODE_RAINBOW;
            end
            lrmc_pkg::ACT_TOGGLE: begin
                n_mode = (r_mode == lrmc_pkg::MODE_OFF) ? lrmc_pkg::MODE_RAINBOW
                                                        : lrmc_pkg::MODE_OFF;
            end
            lrmc_pkg::ACT_RED: begin
                n_mode  = lrmc_pkg::MODE_SOLID;
                n_solid = '{red: r_bright, green: 8'd0, blue: 8'd0};
                result  = n_solid;
            end
            lrmc_pkg::ACT_GREEN: begin
                n_mode  = lrmc_pkg::MODE_SOLID;
                n_solid = '{red: 8'd0, green: r_bright, blue: 8'd0};
                result  = n_solid;
            end
            lrmc_pkg::ACT_BLUE: begin
                n_mode  = lrmc_pkg::MODE_SOLID;
                n_solid = '{red: 8'd0, green: 8'd0, blue: r_bright};
                result  = n_solid;
            end
            default: begin
                if (cmd.want_rainbow) begin
                    n_mode = lrmc_pkg::MODE_RAINBOW;
                end else begin
                    n_mode  = lrmc_pkg::MODE_SOLID;
                    n_solid = '{red: cmd.custom_red, green: cmd.custom_green,
                                blue: cmd.custom_blue};
                    result  = n_solid;
                end
            end
        endcase
    end

    always_comb begin
        if (advance && emits) begin
            n_out_valid = 1'b1;
        end else if (o_color.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright    <= 8'hFF;
            r_mode      <= lrmc_pkg::MODE_RAINBOW;
            r_sector    <= '0;
            r_frac      <= '0;
            r_solid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bright <= i_cfg_wr_data;
            end
            if (advance) begin
                r_mode   <= n_mode;
                r_sector <= n_sector;
                r_frac   <= n_frac;
                r_solid  <= n_solid;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emits) begin
            r_out <= result;
        end
    end

    assign o_color.valid = r_out_valid;
    assign o_color.red   = r_out.red;
    assign o_color.green = r_out.green;
    assign o_color.blue  = r_out.blue;

`ifndef SYNTHESIS
    // The split hue counter must stay inside the 360-step wheel.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frac < lrmc_pkg::FracW'(lrmc_pkg::SectorLen))
        && (r_sector < lrmc_pkg::SectorW'(lrmc_pkg::NumSectors)))
        else $error("hue counter left its range");

    // An emitting item that retires must show up on the color channel.
    a_emit_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emits) |=> o_color.valid)
        else $error("retired color not presented");

    // A silent item must not disturb a stalled color.
    a_silent_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !emits && r_out_valid && !o_color.ready)
        |=> (o_color.valid && $stable(r_out)))
        else $error("silent item disturbed a pending color");
`endif

endmodule

[tb/led_rainbow_mode_controller_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED rainbow mode controller testbench
// Sends directed and random command and tick transfers to the controller,
// predicts every strip color from its own model of the mode, hue and solid
// color, and checks each color transfer in order under random idling on both
// channels and at several brightness settings.
// ----------------------------------------------------------------------------
module led_rainbow_mode_controller_unit_tb;

    localparam int unsigned HueSteps    = 360;
    localparam int unsigned DrainCycles = 6;
    localparam int unsigned CycleLimit  = 500000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    lrmc_cmd_if   cmd_if ();
    lrmc_color_if color_if ();

    led_rainbow_mode_controller_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd         (cmd_if),
        .o_color       (color_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Predicted controller state.
    lrmc_pkg::t_mode strip_mode;
    logic [8:0]      hue_pos;
    lrmc_pkg::t_rgb  solid_rgb;
    logic [7:0]      level;

    lrmc_pkg::t_rgb pending_colors [$];
    int unsigned    err_cnt = 0;
    bit             send_gaps = 1'b1;
    bit             stall_en = 1'b1;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Color sink: ready drops in random bursts while stalls are enabled.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        color_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                color_if.ready <= 1'b0;
                stall_left--;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                color_if.ready <= 1'b0;
            end else begin
                color_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        lrmc_pkg::t_rgb exp_c;
        if (rst_n && color_if.valid && color_if.ready) begin
            if (pending_colors.size() == 0) begin
                $error("unexpected color transfer: red %0d green %0d blue %0d",
                       color_if.red, color_if.green, color_if.blue);
                err_cnt++;
            end else begin
                exp_c = pending_colors.pop_front();
                if (color_if.red !== exp_c.red) begin
                    $error("red: expected %0d, got %0d", exp_c.red, color_if.red);
                    err_cnt++;
                end
                if (color_if.green !== exp_c.green) begin
                    $error("green: expected %0d, got %0d", exp_c.green, color_if.green);
                    err_cnt++;
                end
                if (color_if.blue !== exp_c.blue) begin
                    $error("blue: expected %0d, got %0d", exp_c.blue, color_if.blue);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (CycleLimit) @(posedge clk);
        $display("led_rainbow_mode_controller_unit_tb failed");
        $finish;
    end

    function automatic lrmc_pkg::t_rgb hue_to_rgb(input logic [8:0] h,
                                                  input logic [7:0] b);
        int unsigned f;
        int unsigned rise;
        int unsigned fall;
        lrmc_pkg::t_rgb c;
        f = h % lrmc_pkg::SectorLen;
        rise = (f * b) / lrmc_pkg::SectorLen;
        fall = ((lrmc_pkg::SectorLen - f) * b) / lrmc_pkg::SectorLen;
        case (h / lrmc_pkg::SectorLen)
            0: c = '{red: b, green: 8'(rise), blue: 8'd0};
            1: c = '{red: 8'(fall), green: b, blue: 8'd0};
            2: c = '{red: 8'd0, green: b, blue: 8'(rise)};
            3: c = '{red: 8'd0, green: 8'(fall), blue: b};
            4: c = '{red: 8'(rise), green: 8'd0, blue: b};
            default: c = '{red: b, green: 8'd0, blue: 8'(fall)};
        endcase
        return c;
    endfunction

    // Advances the predicted state by one accepted item and queues its color.
    task automatic predict_color(input lrmc_pkg::t_cmd c);
        lrmc_pkg::t_rgb col;
        bit             emits;
        col = '0;
        emits = 1'b1;
        case (lrmc_pkg::t_action'(c.action))
            lrmc_pkg::ACT_TICK: begin
                case (strip_mode)
                    lrmc_pkg::MODE_RAINBOW: begin
                        col = hue_to_rgb(hue_pos, level);
                        hue_pos = (hue_pos == HueSteps - 1) ? 9'd0 : hue_pos + 9'd1;
                    end
                    lrmc_pkg::MODE_SOLID: col = solid_rgb;
                    default: col = '0;
                endcase
            end
            lrmc_pkg::ACT_OFF: strip_mode = lrmc_pkg::MODE_OFF;
            lrmc_pkg::ACT_ON: begin
                strip_mode = lrmc_pkg::MODE_RAINBOW;
                emits = 1'b0;
            end
            lrmc_pkg::ACT_TOGGLE: begin
                if (strip_mode == lrmc_pkg::MODE_OFF) begin
                    strip_mode = lrmc_pkg::MODE_RAINBOW;
                    emits = 1'b0;
                end else begin
                    strip_mode = lrmc_pkg::MODE_OFF;
                end
            end
            lrmc_pkg::ACT_RED, lrmc_pkg::ACT_GREEN, lrmc_pkg::ACT_BLUE: begin
                strip_mode = lrmc_pkg::MODE_SOLID;
                solid_rgb = '{red:   (c.action == lrmc_pkg::ACT_RED)   ? level : 8'd0,
                              green: (c.action == lrmc_pkg::ACT_GREEN) ? level : 8'd0,
                              blue:  (c.action == lrmc_pkg::ACT_BLUE)  ? level : 8'd0};
                col = solid_rgb;
            end
            default: begin
                if (c.want_rainbow) begin
                    strip_mode = lrmc_pkg::MODE_RAINBOW;
                    emits = 1'b0;
                end else begin
                    strip_mode = lrmc_pkg::MODE_SOLID;
                    solid_rgb = '{red: c.custom_red, green: c.custom_green,
                                  blue: c.custom_blue};
                    col = solid_rgb;
                end
            end
        endcase
        if (emits) begin
            pending_colors.push_back(col);
        end
    endtask

    function automatic lrmc_pkg::t_cmd make_cmd(input lrmc_pkg::t_action act,
                                                input logic [7:0] r,
                                                input logic [7:0] g,
                                                input logic [7:0] b,
                                                input logic rb);
        lrmc_pkg::t_cmd c;
        c.action = act;
        c.custom_red = r;
        c.custom_green = g;
        c.custom_blue = b;
        c.want_rainbow = rb;
        return c;
    endfunction

    function automatic lrmc_pkg::t_cmd rand_cmd(input lrmc_pkg::t_action act);
        return make_cmd(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    // Called and returns at a falling edge; valid stays high for a following item.
    task automatic send_cmd(input lrmc_pkg::t_cmd c);
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.action <= c.action;
        cmd_if.custom_red <= c.custom_red;
        cmd_if.custom_green <= c.custom_green;
        cmd_if.custom_blue <= c.custom_blue;
        cmd_if.want_rainbow <= c.want_rainbow;
        do @(posedge clk); while (!cmd_if.ready);
        predict_color(c);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_cmd(rand_cmd(lrmc_pkg::ACT_TICK));
    endtask

    // Lets every color drain and silent commands settle before the write.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pending_colors.size() != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_brightness(input logic [7:0] b);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= b;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        level = b;
    endtask

    task automatic test_directed_commands();
        send_tick();
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_ON, 8'd0, 8'd0, 8'd0, 1'b0));
        send_tick();
        // Toggle from rainbow turns the strip off and emits black.
        send_cmd(make_cmd(lrmc_pkg::ACT_TOGGLE, 8'd0, 8'd0, 8'd0, 1'b0));
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_OFF, 8'd0, 8'd0, 8'd0, 1'b0));
        // Toggle from off restarts the rainbow silently, hue kept.
        send_cmd(make_cmd(lrmc_pkg::ACT_TOGGLE, 8'd0, 8'd0, 8'd0, 1'b0));
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_RED, 8'd0, 8'd0, 8'd0, 1'b0));
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_GREEN, 8'd0, 8'd0, 8'd0, 1'b0));
        send_cmd(make_cmd(lrmc_pkg::ACT_BLUE, 8'd0, 8'd0, 8'd0, 1'b0));
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_CUSTOM, 8'd255, 8'd0, 8'd170, 1'b0));
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_CUSTOM, 8'd0, 8'd255, 8'd85, 1'b0));
        send_cmd(make_cmd(lrmc_pkg::ACT_CUSTOM, 8'd255, 8'd255, 8'd255, 1'b1));
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_CUSTOM, 8'd0, 8'd0, 8'd0, 1'b0));
        send_cmd(make_cmd(lrmc_pkg::ACT_TOGGLE, 8'd0, 8'd0, 8'd0, 1'b0));
        send_cmd(make_cmd(lrmc_pkg::ACT_ON, 8'd0, 8'd0, 8'd0, 1'b0));
        send_tick();
        send_cmd(make_cmd(lrmc_pkg::ACT_CUSTOM, 8'd170, 8'd85, 8'd0, 1'b1));
    endtask

    // A full hue revolution at full rate, across every sector and the wrap.
    task automatic test_hue_sweep();
        write_brightness(8'd200);
        send_gaps = 1'b0;
        stall_en = 1'b0;
        send_cmd(make_cmd(lrmc_pkg::ACT_ON, 8'd0, 8'd0, 8'd0, 1'b0));
        repeat (HueSteps + 5) send_tick();
    endtask

    // Mostly a command followed by a run of ticks, with some fully random noise.
    task automatic test_random_traffic(input int unsigned n_items, input logic [7:0] b,
                                       input bit gaps, input bit stalls);
        int unsigned sent;
        int unsigned run;
        sent = 0;
        write_brightness(b);
        send_gaps = gaps;
        stall_en = stalls;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_cmd(rand_cmd(lrmc_pkg::t_action'($urandom_range(0, 7))));
                sent++;
            end else begin
                send_cmd(rand_cmd(lrmc_pkg::t_action'($urandom_range(1, 7))));
                run = $urandom_range(0, 24);
                repeat (run) send_tick();
                sent += run + 1;
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'd0;
        cmd_if.valid = 1'b0;
        cmd_if.action = lrmc_pkg::ACT_TICK;
        cmd_if.custom_red = 8'd0;
        cmd_if.custom_green = 8'd0;
        cmd_if.custom_blue = 8'd0;
        cmd_if.want_rainbow = 1'b0;
        strip_mode = lrmc_pkg::MODE_RAINBOW;
        hue_pos = 9'd0;
        solid_rgb = '0;
        level = 8'd255;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_commands();
        test_hue_sweep();
        test_random_traffic(200, 8'd0, 1'b1, 1'b1);
        test_random_traffic(200, 8'd1, 1'b1, 1'b0);
        test_random_traffic(200, 8'($urandom_range(2, 253)), 1'b0, 1'b1);
        test_random_traffic(200, 8'd60, 1'b1, 1'b1);
        test_random_traffic(200, 8'd254, 1'b1, 1'b1);
        test_random_traffic(200, 8'd255, 1'b0, 1'b0);

        drain();
        if (err_cnt == 0) begin
            $display("led_rainbow_mode_controller_unit_tb passed");
        end else begin
            $display("led_rainbow_mode_controller_unit_tb failed");
        end
        $finish;
    end

endmodule
